// File: src/fmbq_pkg.sv
// Shared constants and types for the front/middle/back queue.
`default_nettype none
package fmbq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 3;
	localparam int ST_W     = 2;
	localparam int CA_W     = 7;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 48;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_MID   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_MID    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	localparam logic [VAL_W-1:0] EMPTY_VALUE = '1;

	// Per-cycle instruction broadcast to every cell of the chain.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [IDX_W-1:0] pos;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: src/fmbq_cell.sv
// One storage cell of the queue chain: hold, shift from a neighbor, or load.
`default_nettype none
module fmbq_cell
	import fmbq_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctl_t        ctl,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [VAL_W-1:0] value,
	input  wire logic [VAL_W-1:0] left,
	input  wire logic [VAL_W-1:0] right,
	output logic      [VAL_W-1:0] entry_q,
	output logic      [VAL_W-1:0] sel_value
);

	logic at_pos;
	logic past_pos;

	assign at_pos   = (idx == ctl.pos);
	assign past_pos = (idx > ctl.pos);

	// Only the cell at the access position shows its entry on the read bus.
	assign sel_value = at_pos ? entry_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (past_pos) begin
				entry_q <= left;
			end else if (at_pos) begin
				entry_q <= value;
			end
		end else if (ctl.rem) begin
			if (at_pos || past_pos) begin
				entry_q <= right;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/fmbq_ctrl.sv
// Command decode: access position, status and next count of the queue.
`default_nettype none
module fmbq_ctrl
	import fmbq_pkg::*;
(
	input  wire logic             accept,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [CNT_W-1:0] count,
	output cell_ctl_t             ctl,
	output logic                  is_pop,
	output logic      [ST_W-1:0]  status,
	output logic      [CNT_W-1:0] count_next
);

	logic             full;
	logic             empty;
	logic [CNT_W-1:0] half_up;
	logic [CNT_W-1:0] last;

	assign full    = (count == CNT_W'(CAPACITY));
	assign empty   = (count == '0);
	assign half_up = (count + CNT_W'(1)) >> 1;
	assign last    = count - CNT_W'(1);

	always_comb begin
		ctl        = '0;
		is_pop     = 1'b0;
		status     = ST_OK;
		count_next = count;
		case (command)
			CMD_PUSH_FRONT, CMD_PUSH_MID, CMD_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctl.ins    = accept;
					count_next = count + CNT_W'(1);
					if (command == CMD_PUSH_MID) begin
						ctl.pos = IDX_W'(count >> 1);
					end else if (command == CMD_PUSH_BACK) begin
						ctl.pos = IDX_W'(count);
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_MID, CMD_POP_BACK: begin
				is_pop = 1'b1;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl.rem    = accept;
					count_next = last;
					if (command == CMD_POP_MID) begin
						ctl.pos = IDX_W'(half_up - CNT_W'(1));
					end else if (command == CMD_POP_BACK) begin
						ctl.pos = IDX_W'(last);
					end
				end
			end
			default: begin
				// unused codes leave the queue untouched
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/front_middle_back_queue.sv
// Top level of the front/middle/back queue: cell chain, count and result register.
`default_nettype none
// Ordered queue of signed 32-bit values with push and pop at the front, the
// middle (insert at floor(count/2), remove at ceil(count/2)-1) or the back.
// Each accepted command yields one result. The store is a chain of CAPACITY
// cells; on each transfer every cell holds, loads the new value, or takes the
// entry of its left or right neighbor, so the whole shift completes at the clock
// edge that accepts the command. A command is accepted in the same cycle as it
// arrives whenever the result register is empty or being drained, so the block
// sustains one command per cycle; a stalled result holds further input. The
// popped value is read through the cell at the access position before the
// shift. A pop on an empty queue returns -1 with status 1; a push on a full
// queue is dropped with status 2. count_after carries the low 7 bits of the count.
module front_middle_back_queue
	import fmbq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // command[2:0], value[34:3], zero fill
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [M_DATA_W-1:0] m_tdata   // popped_value[31:0], status[33:32],
	                                           // count_after[40:34], zero fill
);

	logic [CMD_W-1:0] command;
	logic [VAL_W-1:0] value;
	logic             accept;
	cell_ctl_t        ctl;
	logic             is_pop;
	logic [ST_W-1:0]  status;
	logic [CNT_W-1:0] count_next;
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] read_value;
	logic [VAL_W-1:0] popped_value;

	logic [VAL_W-1:0] entry [CAPACITY];
	logic [VAL_W-1:0] sel   [CAPACITY];

	logic [VAL_W-1:0] popped_q;
	logic [ST_W-1:0]  status_q;
	logic [CA_W-1:0]  count_after_q;

	assign command  = s_tdata[CMD_W-1:0];
	assign value    = s_tdata[CMD_W +: VAL_W];
	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	fmbq_ctrl u_ctrl (
		.accept     (accept),
		.command    (command),
		.count      (count_q),
		.ctl        (ctl),
		.is_pop     (is_pop),
		.status     (status),
		.count_next (count_next)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_left
			assign left_v = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_right
			assign right_v = entry[i+1];
		end
		fmbq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (IDX_W'(i)),
			.value     (value),
			.left      (left_v),
			.right     (right_v),
			.entry_q   (entry[i]),
			.sel_value (sel[i])
		);
	end

	// Gather the selected cell onto the read bus.
	always_comb begin
		read_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			read_value = read_value | sel[i];
		end
	end

	always_comb begin
		popped_value = '0;
		if (is_pop) begin
			popped_value = (status == ST_EMPTY) ? EMPTY_VALUE : read_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_next;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q      <= popped_value;
			status_q      <= status;
			count_after_q <= CA_W'(count_next);
		end
	end

	assign m_tdata = {{(M_DATA_W - VAL_W - ST_W - CA_W){1'b0}},
	                  count_after_q, status_q, popped_q};

endmodule
`default_nettype wire

// File: dv/front_middle_back_queue_tb.sv
// Self-checking testbench for the front/middle/back queue: stream stimulus, prediction, checks.
`default_nettype none
module front_middle_back_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fmbq_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam int STALL_LIMIT  = 5000;
	localparam int ITEMS_PHASE  = 300;
	localparam int SEG_LEN      = 60;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [VAL_W-1:0] popped;
		logic [ST_W-1:0]  status;
		logic [CA_W-1:0]  count_after;
	} queue_result_t;

	class fmbq_scoreboard;
		logic [VAL_W-1:0] held_q[$];
		queue_result_t    expected_q[$];
		int               errors = 0;

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		// Apply one accepted command to the shadow queue and queue up its result.
		function void note_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
			queue_result_t res;
			int            idx;
			res.popped = '0;
			res.status = ST_OK;
			case (cmd)
				CMD_PUSH_FRONT, CMD_PUSH_MID, CMD_PUSH_BACK: begin
					if (held_q.size() >= CAPACITY) begin
						res.status = ST_FULL;
					end else if (cmd == CMD_PUSH_FRONT) begin
						held_q.insert(0, val);
					end else if (cmd == CMD_PUSH_MID) begin
						held_q.insert(held_q.size() / 2, val);
					end else begin
						held_q.insert(held_q.size(), val);
					end
				end
				CMD_POP_FRONT, CMD_POP_MID, CMD_POP_BACK: begin
					if (held_q.size() == 0) begin
						res.popped = EMPTY_VALUE;
						res.status = ST_EMPTY;
					end else if (cmd == CMD_POP_FRONT) begin
						res.popped = held_q[0];
						held_q.delete(0);
					end else if (cmd == CMD_POP_MID) begin
						idx = (held_q.size() + 1) / 2 - 1;
						res.popped = held_q[idx];
						held_q.delete(idx);
					end else begin
						idx = held_q.size() - 1;
						res.popped = held_q[idx];
						held_q.delete(idx);
					end
				end
				default: ;
			endcase
			res.count_after = CA_W'(held_q.size());
			expected_q.insert(expected_q.size(), res);
		endfunction

		task check_result(logic [M_DATA_W-1:0] data);
			queue_result_t want;
			logic [VAL_W-1:0] got_val;
			logic [ST_W-1:0]  got_st;
			logic [CA_W-1:0]  got_cnt;
			got_val = data[31:0];
			got_st  = data[33:32];
			got_cnt = data[40:34];
			if (expected_q.size() == 0) begin
				report($sformatf("result transfer with no command pending, data %h", data));
			end else begin
				want = expected_q[0];
				expected_q.delete(0);
				if (got_val !== want.popped)
					report($sformatf("popped_value got %0d expected %0d",
						$signed(got_val), $signed(want.popped)));
				if (got_st !== want.status)
					report($sformatf("status got %0d expected %0d", got_st, want.status));
				if (got_cnt !== want.count_after)
					report($sformatf("count_after got %0d expected %0d",
						got_cnt, want.count_after));
			end
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	fmbq_scoreboard sb = new();
	int src_idle   = 0;
	int sink_stall = 0;
	int hold_left  = 0;
	int quiet_cycles = 0;

	front_middle_back_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Inputs change only at rising edges, so the falling-edge view is what the next edge sees.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_command(s_tdata[2:0], s_tdata[34:3]);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall);
			end
		end
	end

	task send_item(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
		bit took;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'({val, cmd});
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	task drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function logic [VAL_W-1:0] pick_value();
		case ($urandom_range(15))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Push share in percent sets the drift of the fill level.
	function logic [CMD_W-1:0] pick_command(int push_pct);
		logic [CMD_W-1:0] cmd;
		int roll;
		roll = $urandom_range(99);
		if (roll < 3) begin
			cmd = ($urandom_range(1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
		end else if (roll < 3 + push_pct * 97 / 100) begin
			case ($urandom_range(2))
				0:       cmd = CMD_PUSH_FRONT;
				1:       cmd = CMD_PUSH_MID;
				default: cmd = CMD_PUSH_BACK;
			endcase
		end else begin
			case ($urandom_range(2))
				0:       cmd = CMD_POP_FRONT;
				1:       cmd = CMD_POP_MID;
				default: cmd = CMD_POP_BACK;
			endcase
		end
		return cmd;
	endfunction

	int idle_tab[4]  = '{0, 76, 0, 34};
	int stall_tab[4] = '{0, 0, 76, 34};

	initial begin
		int push_pct;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pops, spare codes, extreme values, middle positions at odd and even counts.
		send_item(CMD_POP_FRONT, 32'h1111_1111);
		send_item(CMD_POP_MID, 32'h2222_2222);
		send_item(CMD_POP_BACK, 32'h3333_3333);
		send_item(CMD_SPARE_6, '1);
		send_item(CMD_SPARE_7, '0);
		send_item(CMD_PUSH_BACK, 32'h7FFF_FFFF);
		send_item(CMD_PUSH_FRONT, 32'h8000_0000);
		send_item(CMD_PUSH_MID, 32'h0000_0000);
		send_item(CMD_PUSH_MID, 32'hFFFF_FFFF);
		send_item(CMD_PUSH_BACK, 32'h1234_5678);
		send_item(CMD_SPARE_7, 32'h5A5A_5A5A);
		send_item(CMD_POP_MID, '0);
		send_item(CMD_POP_MID, '1);
		send_item(CMD_PUSH_MID, 32'hA5A5_A5A5);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_POP_BACK, '0);
		send_item(CMD_POP_MID, '0);
		send_item(CMD_POP_MID, '0);
		send_item(CMD_PUSH_MID, 32'hDEAD_BEEF);
		send_item(CMD_POP_MID, '0);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			src_idle   = idle_tab[ph];
			sink_stall = stall_tab[ph];
			for (int n = 0; n < ITEMS_PHASE; n++) begin
				if (n % SEG_LEN == 0) begin
					case ($urandom_range(3))
						0:       push_pct = 90;
						1:       push_pct = 10;
						default: push_pct = 50;
					endcase
				end
				// Back up the block with the sender still offering.
				if (ph == 0 && n == ITEMS_PHASE / 3)
					hold_left = HOLD_CYCLES;
				send_item(pick_command(push_pct), pick_value());
			end
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
src/fmbq_pkg.sv
src/fmbq_cell.sv
src/fmbq_ctrl.sv
src/front_middle_back_queue.sv
dv/front_middle_back_queue_tb.sv
